// File: src/pig_pkg.sv
// shared constants, types and state encoding for the pwm input gamma dimmer
// no dependencies; imported by every module of the block

package pig_pkg;

   localparam int CAP_PORT_W         = 16;
   localparam int MISS_W             = 8;
   localparam int BRIGHT_W           = 7;
   localparam int CMP_W              = 10;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int Q_FRAC             = 16;
   localparam int Q_W                = Q_FRAC + 1;
   localparam int PROD_W             = 2 * Q_W;
   localparam int WHOLE_W            = PROD_W - Q_FRAC;
   localparam int BRIGHT_SCALE       = 10;
   localparam int B10_W              = BRIGHT_W + 4;
   localparam int MISSED_LIMIT       = 5;
   localparam int CMP_MAX            = (1 << CMP_W) - 1;
   localparam int DEF_PWM_FULL_SCALE = 1000;
   localparam int DEF_CAPTURE_WIDTH  = 16;

   localparam logic REG_WHITE = 1'b0;
   localparam logic REG_GREEN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQ1,
      ST_SQ2,
      ST_MULW,
      ST_MULG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic           start;
      logic [Q_W-1:0] a;
      logic [Q_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

endpackage

// File: src/pig_div.sv
// bit-serial restoring divider: floor(dividend * 2^16 / divisor), dividend <= divisor
// one quotient bit per cycle; uses pig_pkg

module pig_div import pig_pkg::*; #(
   parameter int CAP_W = DEF_CAPTURE_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CAP_W-1:0] dividend,
   input  logic [CAP_W-1:0] divisor,
   output logic             done,
   output logic [Q_W-1:0]   quotient
);

   localparam int CntW = $clog2(Q_FRAC);
   localparam logic [CntW-1:0] LastStep = CntW'(Q_FRAC - 1);

   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [CAP_W-1:0] dvs_ff, dvs_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CAP_W:0]   trial;
   logic [CAP_W:0]   diff;
   logic             fits;
   logic             whole_ratio;

   always_comb begin
      trial       = {rem_ff, 1'b0};
      diff        = trial - {1'b0, dvs_ff};
      fits        = trial >= {1'b0, dvs_ff};
      whole_ratio = dividend == divisor;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      done_in     = done_ff;
      if (start) begin
         rem_in  = whole_ratio ? '0 : dividend;
         dvs_in  = divisor;
         quo_in  = Q_W'(whole_ratio);
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/pig_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// shared by the squaring and brightness steps; uses pig_pkg

module pig_mul import pig_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam int CntW = $clog2(Q_W);
   localparam logic [CntW-1:0] LastStep = CntW'(Q_W - 1);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [Q_W-1:0]    mcand_ff, mcand_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [Q_W:0]      partial;

   always_comb begin
      partial  = {1'b0, prod_ff[PROD_W-1:Q_W]}
               + {1'b0, mcand_ff & {Q_W{prod_ff[0]}}};
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      if (req.start) begin
         prod_in  = {{Q_W{1'b0}}, req.b};
         mcand_in = req.a;
         cnt_in   = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[Q_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = prod_ff;

endmodule

// File: src/pwm_in_gamma_dimmer.sv
// top level: register port, sequencer, compare registers and result register
// uses pig_pkg, pig_div and pig_mul

// Each captured period/high pair that differs from the stored pair, with fewer than five
// missed pulses and a nonzero period, sets both LED compares to full scale minus
// brightness*10*(1 - high/period)^4, saturated at 0. Such an item goes from transfer to
// result through the bit-serial divider, then four passes through the shared shift-add
// multiplier (two squarings, then white and green) and last the load of the output
// register. Any other item goes from its transfer to the done state, then to the output
// register. One item is in work at a time; the next is taken while the previous
// result still waits in the output register.
// Brightness registers sit at byte addresses 0 (white) and 4 (green).

module pwm_in_gamma_dimmer import pig_pkg::*; #(
   parameter int PWM_FULL_SCALE = DEF_PWM_FULL_SCALE,
   parameter int CAPTURE_WIDTH  = DEF_CAPTURE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CAP_PORT_W-1:0] req_capture_period,
   input  logic [CAP_PORT_W-1:0] req_capture_high,
   input  logic [MISS_W-1:0]     req_missed_pulses,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CMP_W-1:0]      rsp_white_compare,
   output logic [CMP_W-1:0]      rsp_green_compare,
   output logic                  rsp_compares_updated,
   output logic                  rsp_period_error,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CapW = (CAPTURE_WIDTH < CAP_PORT_W) ? CAPTURE_WIDTH : CAP_PORT_W;
   localparam logic [WHOLE_W-1:0] FullScale = WHOLE_W'(PWM_FULL_SCALE);
   localparam logic [WHOLE_W-1:0] CmpMax    = WHOLE_W'(CMP_MAX);

   state_type state_ff, state_in;

   logic [BRIGHT_W-1:0] white_bright_ff, white_bright_in;
   logic [BRIGHT_W-1:0] green_bright_ff, green_bright_in;
   logic [CapW-1:0]     last_period_ff, last_period_in;
   logic [CapW-1:0]     last_high_ff, last_high_in;
   logic [CMP_W-1:0]    white_cmp_ff, white_cmp_in;
   logic [CMP_W-1:0]    green_cmp_ff, green_cmp_in;
   logic [Q_W-1:0]      g_ff, g_in;
   logic                upd_ff, upd_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0]    rsp_white_ff, rsp_white_in;
   logic [CMP_W-1:0]    rsp_green_ff, rsp_green_in;
   logic                rsp_upd_ff, rsp_upd_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                csr_write;
   logic                accept;
   logic [CapW-1:0]     period;
   logic [CapW-1:0]     high;
   logic [CapW-1:0]     low_time;
   logic                changed;
   logic                in_window;
   logic                zero_period;
   logic                go_calc;
   logic [B10_W-1:0]    white_b10;
   logic [B10_W-1:0]    green_b10;
   logic [Q_W-1:0]      rounded;
   logic [WHOLE_W-1:0]  whole;
   logic [WHOLE_W-1:0]  headroom;
   logic [CMP_W-1:0]    cmp_value;

   logic                div_start;
   logic                div_done;
   logic [Q_W-1:0]      div_quo;
   mul_req_type         mul_req;
   mul_rsp_type         mul_rsp;
   logic                g_load;
   logic                white_load;
   logic                green_load;
   logic                load_rsp;

   pig_div #(
      .CAP_W (CapW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (low_time),
      .divisor  (period),
      .done     (div_done),
      .quotient (div_quo)
   );

   pig_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // register port
   always_comb begin
      csr_write       = psel & penable & pwrite;
      white_bright_in = white_bright_ff;
      green_bright_in = green_bright_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_WHITE: white_bright_in = pwdata[BRIGHT_W-1:0];
            REG_GREEN: green_bright_in = pwdata[BRIGHT_W-1:0];
            default: ;
         endcase
      end
      case (paddr[2])
         REG_WHITE: prdata = CSR_DATA_W'(white_bright_ff);
         REG_GREEN: prdata = CSR_DATA_W'(green_bright_ff);
         default:   prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // item decode
   always_comb begin
      accept      = req_valid & req_ready;
      period      = req_capture_period[CapW-1:0];
      high        = req_capture_high[CapW-1:0];
      low_time    = (high < period) ? (period - high) : '0;
      changed     = (period != last_period_ff) || (high != last_high_ff);
      in_window   = req_missed_pulses < MISS_W'(MISSED_LIMIT);
      zero_period = period == '0;
      go_calc     = changed & in_window & ~zero_period;
   end

   // datapath between multiplier passes
   always_comb begin
      white_b10 = B10_W'(white_bright_ff) * B10_W'(BRIGHT_SCALE);
      green_b10 = B10_W'(green_bright_ff) * B10_W'(BRIGHT_SCALE);
      rounded   = Q_W'(mul_rsp.prod[PROD_W-1:Q_FRAC]) + Q_W'(mul_rsp.prod[Q_FRAC-1]);
      whole     = mul_rsp.prod[PROD_W-1:Q_FRAC] + WHOLE_W'(|mul_rsp.prod[Q_FRAC-1:0]);
      headroom  = (whole >= FullScale) ? '0 : (FullScale - whole);
      cmp_value = (headroom > CmpMax) ? CmpMax[CMP_W-1:0] : headroom[CMP_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = go_calc ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV:  if (div_done) state_in = ST_SQ1;
         ST_SQ1:  if (mul_rsp.done) state_in = ST_SQ2;
         ST_SQ2:  if (mul_rsp.done) state_in = ST_MULW;
         ST_MULW: if (mul_rsp.done) state_in = ST_MULG;
         ST_MULG: if (mul_rsp.done) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready  = 1'b0;
      div_start  = 1'b0;
      mul_req    = '0;
      g_load     = 1'b0;
      white_load = 1'b0;
      green_load = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid & go_calc;
         end
         ST_DIV: begin
            mul_req.start = div_done;
            mul_req.a     = div_quo;
            mul_req.b     = div_quo;
         end
         ST_SQ1: begin
            mul_req.start = mul_rsp.done;
            mul_req.a     = rounded;
            mul_req.b     = rounded;
         end
         ST_SQ2: begin
            mul_req.start = mul_rsp.done;
            mul_req.a     = rounded;
            mul_req.b     = Q_W'(white_b10);
            g_load        = mul_rsp.done;
         end
         ST_MULW: begin
            mul_req.start = mul_rsp.done;
            mul_req.a     = g_ff;
            mul_req.b     = Q_W'(green_b10);
            white_load    = mul_rsp.done;
         end
         ST_MULG: begin
            green_load = mul_rsp.done;
         end
         ST_DONE: begin
            load_rsp = ~rsp_valid_ff | rsp_ready;
         end
         default: ;
      endcase
   end

   // register next values
   always_comb begin
      last_period_in = last_period_ff;
      last_high_in   = last_high_ff;
      upd_in         = upd_ff;
      err_in         = err_ff;
      white_cmp_in   = white_load ? cmp_value : white_cmp_ff;
      green_cmp_in   = green_load ? cmp_value : green_cmp_ff;
      g_in           = g_load ? rounded : g_ff;
      if (accept) begin
         last_period_in = period;
         last_high_in   = high;
         upd_in         = go_calc;
         err_in         = changed & in_window & zero_period;
      end
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_white_in = rsp_white_ff;
      rsp_green_in = rsp_green_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_err_in   = rsp_err_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_white_in = white_cmp_ff;
         rsp_green_in = green_cmp_ff;
         rsp_upd_in   = upd_ff;
         rsp_err_in   = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         white_bright_ff <= '0;
         green_bright_ff <= '0;
         last_period_ff  <= '0;
         last_high_ff    <= '0;
         white_cmp_ff    <= '0;
         green_cmp_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         white_bright_ff <= white_bright_in;
         green_bright_ff <= green_bright_in;
         last_period_ff  <= last_period_in;
         last_high_ff    <= last_high_in;
         white_cmp_ff    <= white_cmp_in;
         green_cmp_ff    <= green_cmp_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff         <= g_in;
      upd_ff       <= upd_in;
      err_ff       <= err_in;
      rsp_white_ff <= rsp_white_in;
      rsp_green_ff <= rsp_green_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_white_compare    = rsp_white_ff;
   assign rsp_green_compare    = rsp_green_ff;
   assign rsp_compares_updated = rsp_upd_ff;
   assign rsp_period_error     = rsp_err_ff;

endmodule

// File: src/pig_checker.sv
// port-level checks for pwm_in_gamma_dimmer, attached by the bind below
// uses pig_pkg

module pig_checker import pig_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CMP_W-1:0]      rsp_white_compare,
   input logic [CMP_W-1:0]      rsp_green_compare,
   input logic                  rsp_compares_updated,
   input logic                  rsp_period_error
);

   logic [CMP_W-1:0] seen_white_ff, seen_white_in;
   logic [CMP_W-1:0] seen_green_ff, seen_green_in;

   // compares of the last result transfer
   always_comb begin
      seen_white_in = seen_white_ff;
      seen_green_in = seen_green_ff;
      if (rsp_valid && rsp_ready) begin
         seen_white_in = rsp_white_compare;
         seen_green_in = rsp_green_compare;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_white_ff <= '0;
         seen_green_ff <= '0;
      end else begin
         seen_white_ff <= seen_white_in;
         seen_green_ff <= seen_green_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_white_compare)
         && $stable(rsp_green_compare) && $stable(rsp_compares_updated)
         && $stable(rsp_period_error))
      else $error("result changed while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_compares_updated && rsp_period_error))
      else $error("update and period error on one result");

   a_compares_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_compares_updated |->
         rsp_white_compare == seen_white_ff && rsp_green_compare == seen_green_ff)
      else $error("compares moved without an update");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

endmodule

bind pwm_in_gamma_dimmer pig_checker u_pig_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_white_compare    (rsp_white_compare),
   .rsp_green_compare    (rsp_green_compare),
   .rsp_compares_updated (rsp_compares_updated),
   .rsp_period_error     (rsp_period_error)
);

// File: test/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for pwm_in_gamma_dimmer: capture transfers in, compare results out
// brightness registers written over the apb-style port between phases
// depends on pig_pkg and the pwm_in_gamma_dimmer top level

module tb;
   import pig_pkg::*;

   localparam int FULL_SCALE  = DEF_PWM_FULL_SCALE;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_GAP     = 19;
   localparam int DRAIN_PAD   = 8;

   typedef struct packed {
      logic [CAP_PORT_W-1:0] period;
      logic [CAP_PORT_W-1:0] high;
      logic [MISS_W-1:0]     missed;
   } capture_type;

   typedef struct packed {
      logic [CMP_W-1:0] white;
      logic [CMP_W-1:0] green;
      logic             updated;
      logic             bad_period;
   } compares_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CAP_PORT_W-1:0] req_capture_period = '0;
   logic [CAP_PORT_W-1:0] req_capture_high = '0;
   logic [MISS_W-1:0]     req_missed_pulses = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CMP_W-1:0]      rsp_white_compare;
   logic [CMP_W-1:0]      rsp_green_compare;
   logic                  rsp_compares_updated;
   logic                  rsp_period_error;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor copy of the block's registers and state
   logic [BRIGHT_W-1:0]   white_level = '0;
   logic [BRIGHT_W-1:0]   green_level = '0;
   logic [CAP_PORT_W-1:0] held_period = '0;
   logic [CAP_PORT_W-1:0] held_high = '0;
   logic [CMP_W-1:0]      held_white = '0;
   logic [CMP_W-1:0]      held_green = '0;

   capture_type  capture_queue[$];
   compares_type awaited_compares[$];
   capture_type  last_cap = '0;

   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   bit quiet = 1'b0;
   int req_wait = 0;
   int rsp_stall = 0;
   int cycle_count = 0;
   int mismatch_count = 0;

   pwm_in_gamma_dimmer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_capture_period   (req_capture_period),
      .req_capture_high     (req_capture_high),
      .req_missed_pulses    (req_missed_pulses),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_white_compare    (rsp_white_compare),
      .rsp_green_compare    (rsp_green_compare),
      .rsp_compares_updated (rsp_compares_updated),
      .rsp_period_error     (rsp_period_error),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // (1 - high/period)^4 in q1.16
   function automatic logic [63:0] gamma_q16(input logic [63:0] per, input logic [63:0] hi);
      logic [63:0] c, q, s;
      c = (hi < per) ? per - hi : 64'd0;
      q = (c << Q_FRAC) / per;
      s = (q * q + 64'd32768) >> Q_FRAC;
      return (s * s + 64'd32768) >> Q_FRAC;
   endfunction

   function automatic logic [CMP_W-1:0] led_compare(input logic [BRIGHT_W-1:0] level,
                                                    input logic [63:0] g);
      logic [63:0] x, whole, r;
      x = 64'(level) * 64'(BRIGHT_SCALE) * g;
      whole = (x + 64'd65535) >> Q_FRAC;
      r = (whole >= 64'(FULL_SCALE)) ? 64'd0 : 64'(FULL_SCALE) - whole;
      if (r > 64'(CMP_MAX)) r = 64'(CMP_MAX);
      return r[CMP_W-1:0];
   endfunction

   function automatic compares_type gamma_compares(input capture_type cap);
      compares_type res;
      logic [63:0] g;
      res.updated = 1'b0;
      res.bad_period = 1'b0;
      if (cap.period != held_period || cap.high != held_high) begin
         if (cap.missed < MISSED_LIMIT) begin
            if (cap.period == '0) begin
               res.bad_period = 1'b1;
            end else begin
               g = gamma_q16(64'(cap.period), 64'(cap.high));
               held_white = led_compare(white_level, g);
               held_green = led_compare(green_level, g);
               res.updated = 1'b1;
            end
         end
         held_period = cap.period;
         held_high = cap.high;
      end
      res.white = held_white;
      res.green = held_green;
      return res;
   endfunction

   function automatic int pick_gap();
      return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_count, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : monitor
      compares_type want;
      cycle_count++;
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      if (req_fire) begin
         awaited_compares.push_back(gamma_compares(
            capture_type'({req_capture_period, req_capture_high, req_missed_pulses})));
      end
      if (rsp_fire) begin
         if (awaited_compares.size() == 0) begin
            report_mismatch("result transfer with none awaited", 1, 0);
         end else begin
            want = awaited_compares.pop_front();
            if (rsp_white_compare !== want.white)
               report_mismatch("white_compare", int'(rsp_white_compare), int'(want.white));
            if (rsp_green_compare !== want.green)
               report_mismatch("green_compare", int'(rsp_green_compare), int'(want.green));
            if (rsp_compares_updated !== want.updated)
               report_mismatch("compares_updated", int'(rsp_compares_updated),
                               int'(want.updated));
            if (rsp_period_error !== want.bad_period)
               report_mismatch("period_error", int'(rsp_period_error), int'(want.bad_period));
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin : capture_driver
      capture_type cap;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (capture_queue.size() > 0) begin
            cap = capture_queue.pop_front();
            req_capture_period <= cap.period;
            req_capture_high <= cap.high;
            req_missed_pulses <= cap.missed;
            req_valid <= 1'b1;
            req_wait <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_sink
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_fire) begin
         n = pick_gap();
         rsp_stall <= n;
         rsp_ready <= (n == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_capture(input int per, input int hi, input int miss);
      capture_type cap;
      cap.period = CAP_PORT_W'(per);
      cap.high = CAP_PORT_W'(hi);
      cap.missed = MISS_W'(miss);
      capture_queue.push_back(cap);
      last_cap = cap;
   endtask

   task automatic write_level(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == REG_WHITE) white_level = data[BRIGHT_W-1:0];
      else green_level = data[BRIGHT_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // sender holds off until every awaited result has arrived
   task automatic wait_idle();
      do @(posedge clock);
      while (capture_queue.size() != 0 || req_valid || awaited_compares.size() != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic fill_random(input int n);
      capture_type cap;
      int kind, made;
      made = 0;
      while (made < n) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 10) begin
            // same pair again, nothing to do for the block
            cap = last_cap;
            cap.missed = MISS_W'($urandom);
         end else begin
            made++;
            cap.period = ($urandom_range(0, 3) == 0) ? CAP_PORT_W'($urandom_range(1, 300))
                                                     : CAP_PORT_W'($urandom_range(1, 65535));
            cap.high = CAP_PORT_W'($urandom_range(0, 32'(cap.period) - 1));
            cap.missed = MISS_W'($urandom_range(0, MISSED_LIMIT - 1));
            if (kind >= 58 && kind < 70) begin
               cap.high = CAP_PORT_W'($urandom);
               cap.missed = MISS_W'($urandom_range(MISSED_LIMIT, 255));
            end else if (kind >= 70 && kind < 78) begin
               cap.period = '0;
               cap.high = CAP_PORT_W'($urandom);
            end else if (kind >= 78 && kind < 90) begin
               cap.high = CAP_PORT_W'($urandom_range(32'(cap.period), 65535));
            end else if (kind >= 90) begin
               cap.period = CAP_PORT_W'($urandom);
               cap.high = CAP_PORT_W'($urandom);
               cap.missed = MISS_W'($urandom);
            end
         end
         queue_capture(int'(cap.period), int'(cap.high), int'(cap.missed));
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] g,
                            input int n, input bit calm);
      wait_idle();
      write_level(REG_WHITE, w);
      write_level(REG_GREEN, g);
      @(posedge clock);
      quiet = calm;
      fill_random(n);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset brightness of zero
      queue_capture(0, 0, 0);
      queue_capture(1000, 250, 0);
      queue_capture(1000, 250, 0);

      wait_idle();
      write_level(REG_WHITE, 100);
      write_level(REG_GREEN, 55);
      @(posedge clock);
      queue_capture(2000, 500, 5);
      queue_capture(2000, 500, 4);
      queue_capture(3000, 500, 4);
      queue_capture(0, 100, 0);
      queue_capture(0, 100, 0);
      queue_capture(0, 0, 0);
      queue_capture(500, 500, 0);
      queue_capture(500, 65535, 0);
      queue_capture(65535, 0, 0);
      queue_capture(65535, 65534, 3);
      queue_capture(1, 0, 255);
      queue_capture(2, 1, 0);
      queue_capture(65535, 65535, 0);
      queue_capture(40000, 1, 4);
      queue_capture(16'hAAAA, 16'h5555, 8'hAA);
      queue_capture(16'hAAAA, 16'h5555, 0);
      queue_capture(16'h5555, 16'hAAAA, 8'h55);
      queue_capture(16'h5555, 16'h2AAA, 0);
      queue_capture(3, 1, 0);

      run_phase(100, 55, 70, 1'b0);
      run_phase(127, 0, 60, 1'b1);
      run_phase(0, 127, 60, 1'b0);
      run_phase($urandom, $urandom, 60, 1'b0);
      run_phase(1, 99, 60, 1'b1);
      run_phase(50, 100, 60, 1'b0);
      run_phase($urandom_range(0, 100), $urandom_range(0, 100), 60, 1'b0);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
